FILE: rtl/rfe_pkg.sv
// shared types, constants and calendar tables for the rtc epoch converter
// no dependencies; used by the interfaces, rfe_convert and the top level
package rfe_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW       = 1;
  localparam logic [CfgIdxW-1:0] CFG_BINARY_MODE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOUR_24_MODE = 1'd1;
  localparam int unsigned CfgDataW      = 1;

  // reset values of the configuration registers
  localparam logic BINARY_MODE_RST  = 1'b0;
  localparam logic HOUR_24_MODE_RST = 1'b1;

  // days from 1970-01-01 to 2000-01-01 (30 years, 7 leap days)
  localparam logic [15:0] BASE_DAYS    = 16'd10957;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;

  typedef enum logic [1:0] {
    STATUS_FRESH   = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic       update_busy;
    logic [7:0] second_raw;
    logic [7:0] minute_raw;
    logic [7:0] hour_raw;
    logic [7:0] day_raw;
    logic [7:0] month_raw;
    logic [7:0] year_raw;
  } in_item_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    status_e     time_status;
  } out_item_t;

  // bcd byte to binary, or pass through in binary mode
  function automatic logic [7:0] decode_field(input logic [7:0] b, input logic binary);
    logic [7:0] bcd;
    bcd = {4'b0, b[3:0]} + 8'(b[7:4]) * 8'd10;
    return binary ? b : bcd;
  endfunction

  // month index 0..11, non-leap lengths
  function automatic logic [4:0] days_in_month(input logic [3:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] d;
    unique case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/rfe_ifs.sv
// valid/ready channel interfaces for clock snapshots and epoch results
// depends on rfe_pkg
interface rfe_in_if;
  logic       valid;
  logic       ready;
  logic       update_busy;
  logic [7:0] second_raw;
  logic [7:0] minute_raw;
  logic [7:0] hour_raw;
  logic [7:0] day_raw;
  logic [7:0] month_raw;
  logic [7:0] year_raw;

  modport source (output valid, update_busy, second_raw, minute_raw, hour_raw,
                  day_raw, month_raw, year_raw, input ready);
  modport sink   (input valid, update_busy, second_raw, minute_raw, hour_raw,
                  day_raw, month_raw, year_raw, output ready);
endinterface

interface rfe_out_if;
  import rfe_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic [1:0]  time_status;

  modport source (output valid, epoch_seconds, time_status, input ready);
  modport sink   (input valid, epoch_seconds, time_status, output ready);
endinterface

FILE: rtl/rfe_convert.sv
// combinational decode, calendar check and epoch arithmetic for one snapshot
// depends on rfe_pkg
module rfe_convert (
  input  rfe_pkg::in_item_t  item_i,
  input  logic               binary_mode_i,
  input  logic               hour_24_mode_i,
  input  logic [31:0]        last_good_i,
  output rfe_pkg::out_item_t result_o,
  output logic               fresh_o
);
  import rfe_pkg::*;

  logic [7:0]  sec, min, day, mon, yr, h24, h12;
  logic        pm, hour_ok, ok, leap;
  logic [4:0]  hour, mlen;
  logic [3:0]  mon_idx;
  logic [6:0]  yr7;
  logic [15:0] days;
  logic [31:0] total;

  always_comb begin
    sec = decode_field(item_i.second_raw, binary_mode_i);
    min = decode_field(item_i.minute_raw, binary_mode_i);
    day = decode_field(item_i.day_raw, binary_mode_i);
    mon = decode_field(item_i.month_raw, binary_mode_i);
    yr  = decode_field(item_i.year_raw, binary_mode_i);
    h24 = decode_field(item_i.hour_raw, binary_mode_i);
    // pm flag stripped before decode in 12-hour mode
    h12 = decode_field({1'b0, item_i.hour_raw[6:0]}, binary_mode_i);
    pm  = item_i.hour_raw[7];

    if (hour_24_mode_i) begin
      hour_ok = (h24 <= 8'd23);
      hour    = h24[4:0];
    end else begin
      hour_ok = (h12 >= 8'd1) && (h12 <= 8'd12);
      // 12 am -> 0, 12 pm -> 12
      hour    = ((h12 == 8'd12) ? 5'd0 : h12[4:0]) + (pm ? 5'd12 : 5'd0);
    end

    mon_idx = mon[3:0] - 4'd1;
    yr7     = yr[6:0];
    // 2000..2099: every fourth year is leap, 2000 included
    leap    = (yr7[1:0] == 2'b00);
    mlen    = (mon_idx == 4'd1 && leap) ? 5'd29 : days_in_month(mon_idx);

    ok = hour_ok && (sec <= 8'd59) && (min <= 8'd59) && (yr <= 8'd99)
         && (mon >= 8'd1) && (mon <= 8'd12)
         && (day >= 8'd1) && (day <= {3'b0, mlen});

    days = BASE_DAYS + 16'(yr7) * 16'd365 + 16'((8'(yr7) + 8'd3) >> 2)
         + 16'(days_before_month(mon_idx))
         + ((mon_idx >= 4'd2 && leap) ? 16'd1 : 16'd0)
         + 16'(day[4:0]) - 16'd1;

    total = 32'(days) * SECS_PER_DAY + 32'(hour) * 32'd3600
          + 32'(min[5:0]) * 32'd60 + 32'(sec[5:0]);

    if (item_i.update_busy) begin
      result_o.epoch_seconds = last_good_i;
      result_o.time_status   = STATUS_BUSY;
      fresh_o                = 1'b0;
    end else if (!ok) begin
      result_o.epoch_seconds = last_good_i;
      result_o.time_status   = STATUS_INVALID;
      fresh_o                = 1'b0;
    end else begin
      result_o.epoch_seconds = total;
      result_o.time_status   = STATUS_FRESH;
      fresh_o                = 1'b1;
    end
  end

endmodule

FILE: rtl/rtc_fields_to_epoch_seconds.sv
// top level: rtc register snapshot to unix epoch seconds, 2000..2099
// depends on rfe_pkg, rfe_ifs and rfe_convert
//
// Each transfer on in_i is one snapshot of raw clock registers (BCD or binary,
// 12- or 24-hour as configured). One result per snapshot leaves on out_o, in
// order: fresh epoch seconds with status fresh, or the last good time with
// status busy (update flag set, takes precedence) or invalid (a field outside
// its calendar range). The block takes one snapshot per cycle while out_o is
// not stalled; each passes the input register and then the result register. The
// conversion is a single pass of decode, table lookups and one day-to-second
// multiply between those registers, and the last good time is updated as a
// result is registered, so a following snapshot always sees it. Configuration
// writes (index 0 binary_mode, index 1 hour_24_mode) belong to idle periods.
module rtc_fields_to_epoch_seconds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfe_pkg::CfgDataW-1:0]  cfg_data_i,
  rfe_in_if.sink                        in_i,
  rfe_out_if.source                     out_o
);
  import rfe_pkg::*;

  // configuration
  logic binary_mode_q, hour_24_mode_q;

  // input register
  in_item_t in_q;
  logic     in_valid_q, in_valid_d;

  // result register and held time
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;
  logic [31:0] last_good_q;

  out_item_t result;
  logic      fresh;
  logic      in_xfer, advance;

  // result register frees when empty or being taken this cycle
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer   = in_i.valid && in_i.ready;

  assign in_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  rfe_convert u_convert (
    .item_i         (in_q),
    .binary_mode_i  (binary_mode_q),
    .hour_24_mode_i (hour_24_mode_q),
    .last_good_i    (last_good_q),
    .result_o       (result),
    .fresh_o        (fresh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binary_mode_q  <= BINARY_MODE_RST;
      hour_24_mode_q <= HOUR_24_MODE_RST;
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      last_good_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BINARY_MODE:  binary_mode_q  <= cfg_data_i[0];
          CFG_HOUR_24_MODE: hour_24_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // held time follows every fresh result as it is registered
      if (advance && in_valid_q && fresh) begin
        last_good_q <= result.epoch_seconds;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.update_busy <= in_i.update_busy;
      in_q.second_raw  <= in_i.second_raw;
      in_q.minute_raw  <= in_i.minute_raw;
      in_q.hour_raw    <= in_i.hour_raw;
      in_q.day_raw     <= in_i.day_raw;
      in_q.month_raw   <= in_i.month_raw;
      in_q.year_raw    <= in_i.year_raw;
    end
    if (advance && in_valid_q) begin
      out_q <= result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.epoch_seconds = out_q.epoch_seconds;
  assign out_o.time_status   = out_q.time_status;

endmodule
